>>> rtl/core/ci64_pkg.sv
// Shared types, codes and constants of the checked 64-bit update ALU.
package ci64_pkg;

    localparam logic [7:0] OperandLen = 8'd8;

    localparam logic [3:0] FN_SET = 4'd0;
    localparam logic [3:0] FN_ADD = 4'd1;
    localparam logic [3:0] FN_SUB = 4'd2;
    localparam logic [3:0] FN_MUL = 4'd3;
    localparam logic [3:0] FN_DIV = 4'd4;
    localparam logic [3:0] FN_MOD = 4'd5;
    localparam logic [3:0] FN_AND = 4'd6;
    localparam logic [3:0] FN_OR  = 4'd7;
    localparam logic [3:0] FN_XOR = 4'd8;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_WRONGTYPE   = 3'd1;
    localparam logic [2:0] ST_MALFORMED   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_WRONGACTION = 3'd4;

    typedef struct packed {
        logic       load;      // capture item and start
        logic       iterate;   // one divide / multiply step
        logic       commit;    // write result into accumulator
        logic       abort;     // set aborted flag
        logic       emit;      // capture result into output register
    } t_ctl_cmd;

    typedef struct packed {
        logic       skip;      // run already aborted: no work, no result
        logic       simple;    // result known after load
        logic       done;      // iterative unit finished
        logic       last;
        logic [2:0] status;
    } t_ctl_sts;

endpackage

>>> rtl/core/ci64_datapath.sv
// Datapath: accumulator, operand checks, shift-add multiplier and restoring divider.
module ci64_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ci64_pkg::t_ctl_cmd   i_cmd,
    input  logic                 i_first,
    input  logic                 i_old_present,
    input  logic [63:0]          i_prior_value,
    input  logic [3:0]           i_func,
    input  logic [63:0]          i_operand,
    input  logic                 i_operand_is_int,
    input  logic [7:0]           i_operand_bytes,
    input  logic                 i_last,
    output ci64_pkg::t_ctl_sts   o_sts,
    output logic [63:0]          o_value,
    output logic [2:0]           o_status
);

    logic [63:0]  r_acc, n_acc_base;
    logic         r_aborted;
    logic [63:0]  r_a, r_b;          // magnitudes
    logic [127:0] r_work;            // mul: product / div: {rem, quot}
    logic [6:0]   r_cnt;
    logic [3:0]   r_func;
    logic         r_neg, r_aneg, r_last, r_simple, r_skip;
    logic [2:0]   r_st;
    logic [63:0]  r_res;
    logic [63:0]  r_oval;
    logic [2:0]   r_ost;

    logic [63:0]  w_amag, w_bmag, w_easy;
    logic [2:0]   w_st;
    logic         w_simple, w_aborted;
    logic [64:0]  w_sum, w_diff;
    logic [63:0]  w_s, w_mulq, w_q, w_rm, w_fin;
    logic [2:0]   w_fst;
    logic [63:0]  w_val;
    logic [2:0]   w_vst;

    always_comb begin
        n_acc_base = i_first ? (i_old_present ? i_prior_value : 64'd0) : r_acc;
        w_aborted  = i_first ? 1'b0 : r_aborted;
        w_amag     = n_acc_base[63] ? (64'd0 - n_acc_base) : n_acc_base;
        w_bmag     = i_operand[63] ? (64'd0 - i_operand) : i_operand;
        w_easy     = 64'd0;
        w_st       = ci64_pkg::ST_OK;
        w_simple   = 1'b1;
        w_s        = 64'd0;
        if (!i_operand_is_int) begin
            w_st = ci64_pkg::ST_WRONGTYPE;
        end else if (i_operand_bytes != ci64_pkg::OperandLen) begin
            w_st = ci64_pkg::ST_MALFORMED;
        end else begin
            unique case (i_func)
                ci64_pkg::FN_SET: w_easy = i_operand;
                ci64_pkg::FN_ADD: begin
                    w_s = n_acc_base + i_operand;
                    w_easy = w_s;
                    if ((~(n_acc_base[63] ^ i_operand[63])) & (n_acc_base[63] ^ w_s[63]))
                        w_st = ci64_pkg::ST_OVERFLOW;
                end
                ci64_pkg::FN_SUB: begin
                    w_s = n_acc_base - i_operand;
                    w_easy = w_s;
                    if ((n_acc_base[63] ^ i_operand[63]) & (n_acc_base[63] ^ w_s[63]))
                        w_st = ci64_pkg::ST_OVERFLOW;
                end
                ci64_pkg::FN_MUL: begin
                    w_simple = 1'b0;
                end
                ci64_pkg::FN_DIV, ci64_pkg::FN_MOD: begin
                    if (i_operand == 64'd0 ||
                        (n_acc_base == {1'b1, 63'd0} && i_operand == '1)) begin
                        w_st = ci64_pkg::ST_OVERFLOW;
                    end else begin
                        w_simple = 1'b0;
                    end
                end
                ci64_pkg::FN_AND: w_easy = n_acc_base & i_operand;
                ci64_pkg::FN_OR:  w_easy = n_acc_base | i_operand;
                ci64_pkg::FN_XOR: w_easy = n_acc_base ^ i_operand;
                default:          w_st = ci64_pkg::ST_WRONGACTION;
            endcase
        end
        if (w_st != ci64_pkg::ST_OK) begin
            w_simple = 1'b1;
        end
    end

    // one step of each iterative form
    assign w_sum  = {1'b0, r_work[127:64]} + (r_work[0] ? {1'b0, r_a} : 65'd0);
    assign w_diff = {1'b0, r_work[126:63]} - {1'b0, r_b};

    // finish: sign and range of multiply, sign of quotient/remainder
    always_comb begin
        w_mulq = r_work[63:0];
        w_q    = r_work[63:0];
        w_rm   = r_work[127:64];
        w_fin  = 64'd0;
        w_fst  = ci64_pkg::ST_OK;
        if (r_func == ci64_pkg::FN_MUL) begin
            if (r_work[127:64] != 64'd0 ||
                (r_neg ? (w_mulq > {1'b1, 63'd0}) : w_mulq[63])) begin
                w_fst = ci64_pkg::ST_OVERFLOW;
            end
            w_fin = r_neg ? (64'd0 - w_mulq) : w_mulq;
        end else if (r_func == ci64_pkg::FN_DIV) begin
            w_fin = r_neg ? (64'd0 - w_q) : w_q;
        end else begin
            w_fin = r_aneg ? (64'd0 - w_rm) : w_rm;
        end
    end

    always_comb begin
        w_vst = r_simple ? r_st : w_fst;
        w_val = r_simple ? r_res : w_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= 64'd0;
            r_aborted <= 1'b0;
            r_cnt     <= 7'd0;
        end else begin
            if (i_cmd.load) begin
                r_acc     <= n_acc_base;
                r_aborted <= w_aborted;
                r_skip    <= w_aborted;
                r_simple  <= w_simple;
                r_st      <= w_st;
                r_res     <= w_easy;
                r_last    <= i_last;
                r_func    <= i_func;
                r_neg     <= n_acc_base[63] ^ i_operand[63];
                r_aneg    <= n_acc_base[63];
                r_a       <= w_amag;
                r_b       <= w_bmag;
                r_cnt     <= 7'd0;
                r_work    <= (i_func == ci64_pkg::FN_MUL) ? {64'd0, w_bmag} : {64'd0, w_amag};
            end else if (i_cmd.iterate) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_func == ci64_pkg::FN_MUL) begin
                    r_work <= {w_sum, r_work[63:1]};
                end else if (!w_diff[64]) begin
                    r_work <= {w_diff[63:0], r_work[62:0], 1'b1};
                end else begin
                    r_work <= {r_work[126:0], 1'b0};
                end
            end
            if (i_cmd.commit) begin
                r_acc <= w_val;
            end
            if (i_cmd.abort) begin
                r_aborted <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_oval <= (w_vst == ci64_pkg::ST_OK) ? w_val : 64'd0;
                r_ost  <= w_vst;
            end
        end
    end

    always_comb begin
        o_sts.skip   = r_skip;
        o_sts.simple = r_simple;
        o_sts.done   = r_cnt[6];
        o_sts.last   = r_last;
        o_sts.status = w_vst;
    end

    assign o_value  = r_oval;
    assign o_status = r_ost;

endmodule

>>> rtl/core/ci64_ctrl.sv
// Controller: sequences load, iteration, commit and result delivery per item.
module ci64_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ci64_pkg::t_ctl_sts   i_sts,
    output ci64_pkg::t_ctl_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_ITER = 2'd2;

    logic [1:0]  r_state, n_state;
    logic        r_ovalid, w_fin;

    assign o_in_ready = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        w_fin   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.skip) begin
                    n_state = S_IDLE;
                end else if (i_sts.simple) begin
                    w_fin   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.iterate = 1'b1;
                    n_state       = S_ITER;
                end
            end
            S_ITER: begin
                if (i_sts.done) begin
                    w_fin   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.iterate = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (w_fin) begin
            o_cmd.commit = (i_sts.status == ci64_pkg::ST_OK);
            o_cmd.abort  = (i_sts.status != ci64_pkg::ST_OK);
            o_cmd.emit   = (i_sts.status != ci64_pkg::ST_OK) || i_sts.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

>>> rtl/core/checked_int64_update_alu_core.sv
// Top level of the checked signed 64-bit update ALU.
// Usage: operation items enter on the s_axis channel; tdata carries
// prior_value, func, operand and operand_bytes, tuser carries first,
// old_present and operand_is_int, tlast marks the last item of a run.
// The result leaves on m_axis: tdata holds value and status.
// Set, add, sub, and, or, xor and any item that fails its checks or
// falls in an aborted run end in the evaluate state after load; mul,
// div and mod iterate in the 64-step shift-add multiplier and the
// restoring divider that share one work register. One item is in work
// at a time. A result is held in an output register; the next item is
// accepted while it waits only if the receiver takes it, so a stalled
// receiver holds the block after at most one finished result.
// A run yields one result: on its last item, or on its first error,
// after which items are dropped until the next first item.
// Reset clears the accumulator, the abort flag and the output valid.
module checked_int64_update_alu_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // prior_value[63:0], func[67:64], operand[131:68], operand_bytes[139:132]
    input  logic [143:0] s_axis_tdata,
    // first[0], old_present[1], operand_is_int[2]
    input  logic [2:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // value[63:0], status[66:64]
    output logic [71:0]  m_axis_tdata
);

    ci64_pkg::t_ctl_cmd w_cmd;
    ci64_pkg::t_ctl_sts w_sts;
    logic [63:0]        w_oval;
    logic [2:0]         w_ost;

    ci64_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_first         (s_axis_tuser[0]),
        .i_old_present   (s_axis_tuser[1]),
        .i_prior_value   (s_axis_tdata[63:0]),
        .i_func          (s_axis_tdata[67:64]),
        .i_operand       (s_axis_tdata[131:68]),
        .i_operand_is_int(s_axis_tuser[2]),
        .i_operand_bytes (s_axis_tdata[139:132]),
        .i_last          (s_axis_tlast),
        .o_sts           (w_sts),
        .o_value         (w_oval),
        .o_status        (w_ost)
    );

    ci64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    assign m_axis_tdata = {5'd0, w_ost, w_oval};

endmodule

>>> tb/checked_int64_update_alu_core_tb.sv
// Testbench of the checked 64-bit update ALU: directed and random runs checked against a predictor.
`timescale 1ns / 1ps
module checked_int64_update_alu_core_tb;

    typedef struct packed {
        logic        first;
        logic        old_present;
        logic [63:0] prior_value;
        logic [3:0]  func;
        logic [63:0] operand;
        logic        operand_is_int;
        logic [7:0]  operand_bytes;
        logic        last;
    } t_op_item;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  status;
    } t_upd_result;

    localparam int unsigned CycleLimit = 2000000;
    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;

    logic [63:0] acc_model = '0;
    logic        aborted_model = 1'b0;
    t_upd_result pending_results[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          recv_hold = 1'b0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;

    always #1 i_clk = ~i_clk;

    checked_int64_update_alu_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [2:0] compute_op(input logic [3:0] fn, input logic [63:0] a,
                                              input logic [63:0] b, output logic [63:0] r);
        logic [63:0]  s;
        logic [127:0] p;
        logic [63:0]  q;
        r = '0;
        case (fn)
            ci64_pkg::FN_SET: begin
                r = b;
            end
            ci64_pkg::FN_ADD: begin
                s = a + b;
                if (a[63] == b[63] && s[63] != a[63]) return ci64_pkg::ST_OVERFLOW;
                r = s;
            end
            ci64_pkg::FN_SUB: begin
                s = a - b;
                if (a[63] != b[63] && s[63] != a[63]) return ci64_pkg::ST_OVERFLOW;
                r = s;
            end
            ci64_pkg::FN_MUL: begin
                p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
                if (p[127:64] != 64'd0) return ci64_pkg::ST_OVERFLOW;
                if ((a[63] ^ b[63]) ? (p[63:0] > MinVal) : (p[63:0] >= MinVal))
                    return ci64_pkg::ST_OVERFLOW;
                r = (a[63] ^ b[63]) ? -p[63:0] : p[63:0];
            end
            ci64_pkg::FN_DIV, ci64_pkg::FN_MOD: begin
                if (b == 64'd0) return ci64_pkg::ST_OVERFLOW;
                if (a == MinVal && b == '1) return ci64_pkg::ST_OVERFLOW;
                if (fn == ci64_pkg::FN_DIV) begin
                    q = magnitude(a) / magnitude(b);
                    r = (a[63] ^ b[63]) ? -q : q;
                end else begin
                    q = magnitude(a) % magnitude(b);
                    r = a[63] ? -q : q;
                end
            end
            ci64_pkg::FN_AND: r = a & b;
            ci64_pkg::FN_OR:  r = a | b;
            ci64_pkg::FN_XOR: r = a ^ b;
            default: return ci64_pkg::ST_WRONGACTION;
        endcase
        return ci64_pkg::ST_OK;
    endfunction

    task automatic predict_update(t_op_item it);
        logic [2:0]  st;
        logic [63:0] r;
        if (it.first) begin
            aborted_model = 1'b0;
            acc_model = it.old_present ? it.prior_value : '0;
        end
        if (aborted_model) return;
        if (!it.operand_is_int) st = ci64_pkg::ST_WRONGTYPE;
        else if (it.operand_bytes != ci64_pkg::OperandLen) st = ci64_pkg::ST_MALFORMED;
        else st = compute_op(it.func, acc_model, it.operand, r);
        if (st != ci64_pkg::ST_OK) begin
            aborted_model = 1'b1;
            pending_results.push_back('{value: '0, status: st});
        end else begin
            acc_model = r;
            if (it.last) pending_results.push_back('{value: acc_model, status: ci64_pkg::ST_OK});
        end
    endtask

    task automatic send_item(t_op_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, it.operand_bytes, it.operand, it.func, it.prior_value};
        s_axis_tuser <= {it.operand_is_int, it.old_present, it.first};
        s_axis_tlast <= it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_update(it);
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_upd_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value  = m_axis_tdata[63:0];
            got.status = m_axis_tdata[66:64];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value %h status %0d, got value %h status %0d",
                                 want.value, want.status, got.value, got.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("[checked_int64_update_alu_core] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = MinVal;
            1: v = MaxVal;
            2: v = '1;
            3: v = '0;
            4: v = {{56{v[63]}}, v[7:0]};
            5: v = {{32{v[63]}}, v[31:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_op_item make_op(logic first, logic [3:0] fn, logic [63:0] opnd,
                                         logic last);
        t_op_item it;
        it.first = first;
        it.old_present = 1'b0;
        it.prior_value = '0;
        it.func = fn;
        it.operand = opnd;
        it.operand_is_int = 1'b1;
        it.operand_bytes = ci64_pkg::OperandLen;
        it.last = last;
        return it;
    endfunction

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_op_item it;
        it = make_op(1'b1, ci64_pkg::FN_SET, MaxVal, 1'b0); send_item(it);
        send_item(make_op(1'b0, ci64_pkg::FN_ADD, 64'd1, 1'b1));
        it = make_op(1'b1, ci64_pkg::FN_ADD, -64'sd5, 1'b1);
        it.old_present = 1'b1; it.prior_value = MinVal;
        send_item(it);
        it = make_op(1'b1, ci64_pkg::FN_SUB, 64'd1, 1'b0);
        it.old_present = 1'b1; it.prior_value = MinVal;
        send_item(it);
        send_item(make_op(1'b0, ci64_pkg::FN_XOR, 64'd3, 1'b1));
        it = make_op(1'b1, ci64_pkg::FN_MUL, 64'd2, 1'b1);
        it.old_present = 1'b1; it.prior_value = 64'h4000_0000_0000_0000;
        send_item(it);
        it = make_op(1'b1, ci64_pkg::FN_MUL, -64'sd2, 1'b1);
        it.old_present = 1'b1; it.prior_value = 64'h4000_0000_0000_0000;
        send_item(it);
        it = make_op(1'b1, ci64_pkg::FN_DIV, '1, 1'b1);
        it.old_present = 1'b1; it.prior_value = MinVal;
        send_item(it);
        it = make_op(1'b1, ci64_pkg::FN_MOD, '1, 1'b1);
        it.old_present = 1'b1; it.prior_value = MinVal;
        send_item(it);
        it = make_op(1'b1, ci64_pkg::FN_DIV, '0, 1'b1);
        it.old_present = 1'b1; it.prior_value = 64'd7;
        send_item(it);
        it = make_op(1'b1, ci64_pkg::FN_MOD, 64'd3, 1'b0);
        it.old_present = 1'b1; it.prior_value = -64'sd7;
        send_item(it);
        send_item(make_op(1'b0, ci64_pkg::FN_OR, 64'hF0, 1'b0));
        send_item(make_op(1'b0, ci64_pkg::FN_AND, MaxVal, 1'b1));
        send_item(make_op(1'b0, ci64_pkg::FN_DIV, -64'sd2, 1'b1));
        it = make_op(1'b1, ci64_pkg::FN_SET, 64'd1, 1'b0); it.operand_is_int = 1'b0;
        send_item(it);
        send_item(make_op(1'b0, ci64_pkg::FN_ADD, 64'd1, 1'b1));
        it = make_op(1'b1, ci64_pkg::FN_SET, 64'd1, 1'b1); it.operand_bytes = 8'hFF;
        send_item(it);
        it = make_op(1'b1, ci64_pkg::FN_SET, 64'd1, 1'b1); it.operand_bytes = 8'd0;
        send_item(it);
        send_item(make_op(1'b1, 4'd9, 64'd1, 1'b1));
        send_item(make_op(1'b1, 4'd15, 64'd1, 1'b0));
        send_item(make_op(1'b1, ci64_pkg::FN_MUL, MinVal, 1'b1));
        drain_results();
    endtask

    task automatic test_random(int unsigned n);
        t_op_item it;
        int unsigned len;
        int unsigned k;
        k = 0;
        while (k < n) begin
            len = $urandom_range(1, 6);
            for (int unsigned j = 0; j < len; j++) begin
                it.first = (j == 0) ? 1'b1 : ($urandom_range(19) == 0);
                it.old_present = 1'($urandom_range(1));
                it.prior_value = rand_word();
                it.func = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
                                                     4'($urandom_range(8));
                it.operand = rand_word();
                if ($urandom_range(3) == 0) it.operand = {{60{it.operand[3]}}, it.operand[3:0]};
                it.operand_is_int = ($urandom_range(24) != 0);
                it.operand_bytes = ($urandom_range(24) == 0) ? 8'($urandom) :
                                                               ci64_pkg::OperandLen;
                it.last = (j == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                send_item(it);
                k++;
            end
        end
    endtask

    task automatic test_backpressure();
        t_op_item it;
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 6; i++) begin
                it = make_op(1'b1, ci64_pkg::FN_ADD, 64'(i), 1'b1);
                send_item(it);
            end
        join
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 31; recv_idle_pct = 68;
        test_random(700);
        drain_results();
        send_idle_pct = 68; recv_idle_pct = 31;
        test_random(650);
        drain_results();
        test_backpressure();
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(650);
        drain_results();
        $display("covered %0d items and %0d results over all opcodes, errors and stalls",
                 items_sent, results_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[checked_int64_update_alu_core] OK");
        end else begin
            $display("[checked_int64_update_alu_core] ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/ci64_pkg.sv
rtl/core/ci64_datapath.sv
rtl/core/ci64_ctrl.sv
rtl/core/checked_int64_update_alu_core.sv
tb/checked_int64_update_alu_core_tb.sv
